// File: design/bffd_pkg.sv
// ----------------------------------------------------------------------------
// bffd_pkg
// Shared types and constants of the box filter fractional decimator: default
// widths, register reset values, register indexes and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bffd_pkg;

   localparam int DEF_SAMPLE_BITS = 16;
   localparam int DEF_RATE_BITS   = 18;
   localparam int DEF_COUNT_BITS  = 32;

   localparam int IN_RATE_RESET  = 48000;
   localparam int OUT_RATE_RESET = 16000;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_RATE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_RATE     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_COUNT = 3'd3;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic mul_sel_rest;
      logic add_en;
      logic take_boundary;
      logic consume_rest;
      logic clear_interval;
      logic div_start;
      logic div_step;
      logic out_load;
   } bffd_cmd_type;

   typedef struct packed {
      logic take_ok;
      logic rest_ge_utb;
      logic given_lt_count;
      logic last_input;
      logic div_done;
      logic out_free;
   } bffd_status_type;

endpackage

// File: design/box_filter_fractional_decimator_unit.sv
// ----------------------------------------------------------------------------
// box_filter_fractional_decimator_unit
// Area-averaging fractional downsampler: each output sample is the rounded
// mean of the input over one interval of in_rate/out_rate input samples.
// ----------------------------------------------------------------------------
// An input sample that is dropped (bad rates, stream complete) is taken and
// discarded. A sample that closes an interval beyond output_count emits
// nothing, a sample that closes an interval within it emits a mean, and the
// last sample of the stream can emit a second one. The serial divider yields
// one quotient bit per cycle over SAMPLE_BITS + 1 bits; a pending result that
// is not taken adds its wait before the next mean is stored.
// Any write to registers 0..3 restarts the stream.
module box_filter_fractional_decimator_unit #(
   parameter int SAMPLE_BITS = bffd_pkg::DEF_SAMPLE_BITS,
   parameter int RATE_BITS   = bffd_pkg::DEF_RATE_BITS,
   parameter int COUNT_BITS  = bffd_pkg::DEF_COUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bffd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((COUNT_BITS > RATE_BITS) ? COUNT_BITS : RATE_BITS)-1:0] csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_mean_sample,
   output logic                                rsp_final_output
);
   import bffd_pkg::*;

   localparam int CSR_BITS = (COUNT_BITS > RATE_BITS) ? COUNT_BITS : RATE_BITS;

   bffd_cmd_type    cmd;
   bffd_status_type status;
   logic            csr_we;

   assign csr_we = csr_valid && csr_ready;

   bffd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready),
      .csr_ready (csr_ready)
   );

   bffd_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .RATE_BITS   (RATE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .CSR_BITS    (CSR_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_sample  (rsp_mean_sample),
      .rsp_final_output (rsp_final_output)
   );

endmodule

// File: design/bffd_ctrl.sv
// ----------------------------------------------------------------------------
// bffd_ctrl
// Sequencer of the decimator: walks one item through the head interval,
// the body and the end-of-stream tail, and starts the divider for each mean.
// ----------------------------------------------------------------------------
module bffd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       csr_valid,
   input  bffd_pkg::bffd_status_type  status,
   output bffd_pkg::bffd_cmd_type     cmd,
   output logic                       req_ready,
   output logic                       csr_ready
);
   import bffd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_MUL_HEAD,
      ST_ADD_HEAD,
      ST_DROP,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_EMIT,
      ST_MUL_BODY,
      ST_ADD_BODY,
      ST_TAIL_CHECK,
      ST_MUL_TAIL,
      ST_ADD_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      tail_ff, tail_in;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      tail_in  = tail_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid && status.take_ok) begin
               cmd.load = 1'b1;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = status.rest_ge_utb ? ST_MUL_HEAD : ST_MUL_BODY;
         end
         ST_MUL_HEAD: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD_HEAD;
         end
         ST_ADD_HEAD: begin
            cmd.add_en        = 1'b1;
            cmd.take_boundary = 1'b1;
            tail_in           = 1'b0;
            state_in          = status.given_lt_count ? ST_DIV_LOAD : ST_DROP;
         end
         ST_DROP: begin
            cmd.clear_interval = 1'b1;
            state_in           = ST_MUL_BODY;
         end
         ST_DIV_LOAD: begin
            cmd.div_start      = 1'b1;
            cmd.clear_interval = 1'b1;
            state_in           = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tail_ff ? ST_IDLE : ST_MUL_BODY;
            end
         end
         ST_MUL_BODY: begin
            cmd.mul_en       = 1'b1;
            cmd.mul_sel_rest = 1'b1;
            state_in         = ST_ADD_BODY;
         end
         ST_ADD_BODY: begin
            cmd.add_en       = 1'b1;
            cmd.consume_rest = 1'b1;
            state_in         = ST_TAIL_CHECK;
         end
         ST_TAIL_CHECK: begin
            if (status.last_input && status.given_lt_count) begin
               state_in = ST_MUL_TAIL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL_TAIL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_ADD_TAIL;
         end
         ST_ADD_TAIL: begin
            cmd.add_en = 1'b1;
            tail_in    = 1'b1;
            state_in   = ST_DIV_LOAD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

// File: design/bffd_dp.sv
// ----------------------------------------------------------------------------
// bffd_dp
// Datapath of the decimator: configuration registers, stream position,
// weighted sum with one registered multiplier, a restoring divider that
// yields one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module bffd_dp #(
   parameter int SAMPLE_BITS = bffd_pkg::DEF_SAMPLE_BITS,
   parameter int RATE_BITS   = bffd_pkg::DEF_RATE_BITS,
   parameter int COUNT_BITS  = bffd_pkg::DEF_COUNT_BITS,
   parameter int CSR_BITS    = (COUNT_BITS > RATE_BITS) ? COUNT_BITS : RATE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bffd_pkg::bffd_cmd_type                cmd,
   output bffd_pkg::bffd_status_type             status,
   input  logic                                  csr_we,
   input  logic [bffd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_BITS-1:0]                   csr_data,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_mean_sample,
   output logic                                  rsp_final_output
);
   import bffd_pkg::*;

   localparam int SUM_BITS  = SAMPLE_BITS + RATE_BITS + 1;
   localparam int QUO_BITS  = SAMPLE_BITS + 1;
   localparam int DCNT_BITS = $clog2(QUO_BITS + 1);
   localparam logic [QUO_BITS-1:0] POS_LIM = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [QUO_BITS-1:0] NEG_LIM = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

   logic [RATE_BITS-1:0]          in_rate_ff, in_rate_in;
   logic [RATE_BITS-1:0]          out_rate_ff, out_rate_in;
   logic [COUNT_BITS-1:0]         in_count_ff, in_count_in;
   logic [COUNT_BITS-1:0]         out_count_ff, out_count_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [RATE_BITS-1:0]          utb_ff, utb_in;
   logic [RATE_BITS-1:0]          rest_ff, rest_in;
   logic [COUNT_BITS-1:0]         seen_ff, seen_in;
   logic [COUNT_BITS-1:0]         given_ff, given_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SUM_BITS-1:0]    prod_ff, prod_in;
   logic                          neg_ff, neg_in;
   logic [RATE_BITS-1:0]          rem_ff, rem_in;
   logic [QUO_BITS-1:0]           quo_ff, quo_in;
   logic [DCNT_BITS-1:0]          dcnt_ff, dcnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic                          final_ff, final_in;

   logic                          restart;
   logic [RATE_BITS-1:0]          mul_op;
   logic [SUM_BITS-1:0]           mag;
   logic [SUM_BITS-1:0]           numer;
   logic [RATE_BITS:0]            trial;
   logic [RATE_BITS:0]            diff;
   logic                          ge;
   logic [QUO_BITS-1:0]           quo_sat;
   logic [QUO_BITS-1:0]           quo_neg;
   logic [COUNT_BITS-1:0]         given_next;

   assign mul_op     = cmd.mul_sel_rest ? rest_ff : utb_ff;
   assign prod_in    = SUM_BITS'(x_ff * $signed({1'b0, mul_op}));
   assign mag        = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign numer      = mag + SUM_BITS'(in_rate_ff >> 1);
   assign trial      = {rem_ff, quo_ff[QUO_BITS-1]};
   assign diff       = trial - {1'b0, in_rate_ff};
   assign ge         = (trial >= {1'b0, in_rate_ff});
   assign given_next = given_ff + COUNT_BITS'(1);

   always_comb begin
      if (neg_ff) begin
         quo_sat = (quo_ff > NEG_LIM) ? NEG_LIM : quo_ff;
      end else begin
         quo_sat = (quo_ff > POS_LIM) ? POS_LIM : quo_ff;
      end
      quo_neg = ~quo_sat + QUO_BITS'(1);
   end

   always_comb begin
      in_rate_in   = in_rate_ff;
      out_rate_in  = out_rate_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      sum_in       = sum_ff;
      utb_in       = utb_ff;
      rest_in      = rest_ff;
      seen_in      = seen_ff;
      given_in     = given_ff;
      x_in         = x_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      mean_in      = mean_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      restart      = 1'b0;

      if (cmd.load) begin
         x_in    = req_sample;
         rest_in = out_rate_ff;
         seen_in = seen_ff + COUNT_BITS'(1);
      end
      if (cmd.add_en) begin
         sum_in = sum_ff + prod_ff;
      end
      if (cmd.take_boundary) begin
         rest_in = rest_ff - utb_ff;
      end
      if (cmd.consume_rest) begin
         utb_in = utb_ff - rest_ff;
      end
      if (cmd.clear_interval) begin
         sum_in = '0;
         utb_in = in_rate_ff;
      end
      if (cmd.div_start) begin
         neg_in  = sum_ff[SUM_BITS-1];
         rem_in  = numer[SUM_BITS-1:QUO_BITS];
         quo_in  = numer[QUO_BITS-1:0];
         dcnt_in = DCNT_BITS'(QUO_BITS);
      end
      if (cmd.div_step) begin
         rem_in  = ge ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
         quo_in  = {quo_ff[QUO_BITS-2:0], ge};
         dcnt_in = dcnt_ff - DCNT_BITS'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         mean_in      = neg_ff ? quo_neg[SAMPLE_BITS-1:0] : quo_sat[SAMPLE_BITS-1:0];
         final_in     = (given_next == out_count_ff);
         given_in     = given_next;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_IN_RATE: begin
               in_rate_in = csr_data[RATE_BITS-1:0];
               restart    = 1'b1;
            end
            CSR_OUT_RATE: begin
               out_rate_in = csr_data[RATE_BITS-1:0];
               restart     = 1'b1;
            end
            CSR_INPUT_COUNT: begin
               in_count_in = csr_data[COUNT_BITS-1:0];
               restart     = 1'b1;
            end
            CSR_OUTPUT_COUNT: begin
               out_count_in = csr_data[COUNT_BITS-1:0];
               restart      = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      if (restart) begin
         sum_in   = '0;
         utb_in   = in_rate_in;
         seen_in  = '0;
         given_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rate_ff   <= RATE_BITS'(IN_RATE_RESET);
         out_rate_ff  <= RATE_BITS'(OUT_RATE_RESET);
         in_count_ff  <= '0;
         out_count_ff <= '0;
         sum_ff       <= '0;
         utb_ff       <= RATE_BITS'(IN_RATE_RESET);
         rest_ff      <= '0;
         seen_ff      <= '0;
         given_ff     <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         sum_ff       <= sum_in;
         utb_ff       <= utb_in;
         rest_ff      <= rest_in;
         seen_ff      <= seen_in;
         given_ff     <= given_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      prod_ff  <= cmd.mul_en ? prod_in : prod_ff;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      mean_ff  <= mean_in;
      final_ff <= final_in;
   end

   assign status.take_ok        = (out_rate_ff != '0) && (out_rate_ff <= in_rate_ff)
                                  && (seen_ff < in_count_ff);
   assign status.rest_ge_utb    = (rest_ff >= utb_ff);
   assign status.given_lt_count = (given_ff < out_count_ff);
   assign status.last_input     = (seen_ff == in_count_ff);
   assign status.div_done       = (dcnt_ff == '0);
   assign status.out_free       = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_sample  = mean_ff;
   assign rsp_final_output = final_ff;

`ifndef SYNTHESIS
   a_utb_in_interval: assert property (@(posedge clock) disable iff (reset)
      status.take_ok |-> (utb_ff != '0) && (utb_ff <= in_rate_ff))
      else $error("boundary distance outside the output interval");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while still pending");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (dcnt_ff != '0) |-> (rem_ff < in_rate_ff))
      else $error("divider remainder not below divisor");

   a_div_not_disturbed: assert property (@(posedge clock) disable iff (reset)
      (dcnt_ff != '0) |-> !cmd.load && !cmd.out_load && !cmd.div_start)
      else $error("divider disturbed while running");
`endif

endmodule

// File: tb/bffd_mean_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bffd_mean_checker
// Watches the register, sample and mean channels of the box filter decimator,
// tracks the area-weighted sum of every output interval on its own and
// compares each mean taken from the block, value and last flag, in order.
// ----------------------------------------------------------------------------
module bffd_mean_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [bffd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bffd_pkg::DEF_COUNT_BITS-1:0]    csr_data,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [bffd_pkg::DEF_SAMPLE_BITS-1:0] req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [bffd_pkg::DEF_SAMPLE_BITS-1:0] rsp_mean_sample,
   input  logic                                   rsp_final_output,
   output int                                     error_count,
   output int                                     pending_count
);

   localparam int     SBITS     = bffd_pkg::DEF_SAMPLE_BITS;
   localparam longint MEAN_MAX  = (longint'(1) << (SBITS - 1)) - 1;
   localparam longint MEAN_MIN  = -MEAN_MAX - 1;
   localparam longint RATE_MASK = (longint'(1) << bffd_pkg::DEF_RATE_BITS) - 1;

   typedef struct {
      logic signed [SBITS-1:0] mean;
      logic                    is_last;
   } mean_item_type;

   mean_item_type expected_means[$];

   longint in_rate;
   longint out_rate;
   longint stream_len;
   longint outputs_wanted;

   longint area_sum;
   longint units_left;
   longint samples_taken;
   longint means_given;

   longint sample_x;
   longint rest;
   int     mismatches = 0;
   mean_item_type head;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic restart_stream();
      area_sum      = 0;
      units_left    = in_rate;
      samples_taken = 0;
      means_given   = 0;
   endtask

   task automatic close_interval();
      longint mag;
      longint quo;
      longint val;
      mean_item_type item;
      mag = (area_sum < 0) ? -area_sum : area_sum;
      quo = (mag + in_rate / 2) / in_rate;
      if (quo > MEAN_MAX + 1) quo = MEAN_MAX + 1;
      val = (area_sum < 0) ? -quo : quo;
      if (val > MEAN_MAX) val = MEAN_MAX;
      if (val < MEAN_MIN) val = MEAN_MIN;
      means_given  = means_given + 1;
      item.mean    = val[SBITS-1:0];
      item.is_last = (means_given == outputs_wanted);
      expected_means.push_back(item);
      area_sum   = 0;
      units_left = in_rate;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         in_rate        = bffd_pkg::IN_RATE_RESET;
         out_rate       = bffd_pkg::OUT_RATE_RESET;
         stream_len     = 0;
         outputs_wanted = 0;
         restart_stream();
         expected_means.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bffd_pkg::CSR_IN_RATE: begin
                  in_rate = longint'(csr_data) & RATE_MASK;
                  restart_stream();
               end
               bffd_pkg::CSR_OUT_RATE: begin
                  out_rate = longint'(csr_data) & RATE_MASK;
                  restart_stream();
               end
               bffd_pkg::CSR_INPUT_COUNT: begin
                  stream_len = longint'(csr_data);
                  restart_stream();
               end
               bffd_pkg::CSR_OUTPUT_COUNT: begin
                  outputs_wanted = longint'(csr_data);
                  restart_stream();
               end
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected mean %0d last %0b, nothing pending",
                           $time, rsp_mean_sample, rsp_final_output);
            end else begin
               head = expected_means.pop_front();
               if (head.mean !== rsp_mean_sample || head.is_last !== rsp_final_output) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mean mismatch, expected %0d last %0b, got %0d last %0b",
                              $time, head.mean, head.is_last, rsp_mean_sample,
                              rsp_final_output);
               end
            end
         end

         if (req_valid && req_ready && out_rate != 0 && out_rate <= in_rate &&
             samples_taken < stream_len) begin
            sample_x = req_sample;
            samples_taken++;
            rest = out_rate;
            if (rest >= units_left) begin
               area_sum += sample_x * units_left;
               rest -= units_left;
               if (means_given < outputs_wanted) begin
                  close_interval();
               end else begin
                  area_sum   = 0;
                  units_left = in_rate;
               end
            end
            area_sum += sample_x * rest;
            units_left -= rest;
            if (samples_taken == stream_len && means_given < outputs_wanted) begin
               area_sum += sample_x * units_left;
               close_interval();
            end
         end
      end
      pending_count <= expected_means.size();
      error_count   <= mismatches;
   end

endmodule

// File: tb/box_filter_fractional_decimator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_fractional_decimator_unit_tb
// Drives register settings and sample streams into the decimator, directed
// edge cases first and then random streams, with bursty input, a stalling
// output side and one long output hold-off; the checker predicts every mean.
// ----------------------------------------------------------------------------
module box_filter_fractional_decimator_unit_tb;

   localparam int     SBITS         = bffd_pkg::DEF_SAMPLE_BITS;
   localparam int     IBITS         = bffd_pkg::CSR_INDEX_BITS;
   localparam int     DBITS         = bffd_pkg::DEF_COUNT_BITS;
   localparam int     CYCLE_LIMIT   = 1000000;
   localparam int     SETTLE_CYCLES = 120;
   localparam int     HOLD_CYCLES   = 600;
   localparam int     ITEM_TARGET   = 1350;
   localparam longint RATE_MAX      = (longint'(1) << bffd_pkg::DEF_RATE_BITS) - 1;
   localparam longint COUNT_MAX     = (longint'(1) << DBITS) - 1;
   localparam logic [IBITS-1:0] CSR_SPARE = '1;
   localparam logic signed [SBITS-1:0] SAMPLE_MAX = {1'b0, {(SBITS-1){1'b1}}};
   localparam logic signed [SBITS-1:0] SAMPLE_MIN = {1'b1, {(SBITS-1){1'b0}}};

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_valid        = 1'b0;
   logic                     csr_ready;
   logic [IBITS-1:0]         csr_index        = '0;
   logic [DBITS-1:0]         csr_data         = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic signed [SBITS-1:0]  req_sample       = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic signed [SBITS-1:0]  rsp_mean_sample;
   logic                     rsp_final_output;

   int   error_count;
   int   pending_count;
   int   cycles      = 0;
   bit   pressure_on = 1'b0;
   bit   hold_done   = 1'b0;

   logic signed [SBITS-1:0] directed[$];

   box_filter_fractional_decimator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_sample  (rsp_mean_sample),
      .rsp_final_output (rsp_final_output)
   );

   bffd_mean_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_sample  (rsp_mean_sample),
      .rsp_final_output (rsp_final_output),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL box_filter_fractional_decimator_unit");
         $finish;
      end
   end

   initial begin
      int mode;
      int span;
      forever begin
         if (pressure_on && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 60);
            repeat (span) begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  default: rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic write_reg(input logic [IBITS-1:0] idx, input logic [DBITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input longint rin, input longint rout, input longint ic,
                            input longint oc);
      write_reg(bffd_pkg::CSR_IN_RATE, DBITS'(rin));
      write_reg(bffd_pkg::CSR_OUT_RATE, DBITS'(rout));
      write_reg(bffd_pkg::CSR_INPUT_COUNT, DBITS'(ic));
      write_reg(bffd_pkg::CSR_OUTPUT_COUNT, DBITS'(oc));
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [SBITS-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic play_directed();
      foreach (directed[i]) send_sample(directed[i]);
      req_valid <= 1'b0;
      settle();
   endtask

   function automatic logic signed [SBITS-1:0] rand_sample();
      case ($urandom_range(0, 11))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return SBITS'($urandom);
      endcase
   endfunction

   task automatic run_random_phase(input int n);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < n) begin
            send_sample(rand_sample());
            sent++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 && sent < n) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      settle();
   endtask

   initial begin
      longint rin;
      longint rout;
      longint ic;
      longint oc;
      longint full;
      int     n;
      int     kind;
      int     phase;
      longint sent_items;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no stream configured: dropped
      directed = '{SAMPLE_MAX};
      play_directed();

      // bad rates: dropped
      configure(5, 0, COUNT_MAX, COUNT_MAX);
      directed = '{SAMPLE_MIN};
      play_directed();
      write_reg(bffd_pkg::CSR_IN_RATE, DBITS'(5));
      write_reg(bffd_pkg::CSR_OUT_RATE, DBITS'(6));
      write_reg(bffd_pkg::CSR_INPUT_COUNT, DBITS'(10));
      write_reg(bffd_pkg::CSR_OUTPUT_COUNT, DBITS'(0));
      write_reg(CSR_SPARE, '1);
      csr_valid <= 1'b0;
      directed = '{16'sh1234};
      play_directed();

      // fractional boundaries, end of stream closes a partial interval, extras dropped
      configure(3, 2, 7, 5);
      directed = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 0, -1, 1, 12345, -12345};
      play_directed();

      // more intervals than outputs asked for
      configure(2, 1, 4, 1);
      directed = '{-3, 5, -7, 9};
      play_directed();

      // outputs asked for beyond what the stream can give
      configure(4, 1, 5, 9);
      directed = '{-2, -2, -2, -1, 3};
      play_directed();

      // widest rates, one output per sample
      configure(RATE_MAX, RATE_MAX, 3, 3);
      directed = '{SAMPLE_MAX, SAMPLE_MIN, -1};
      play_directed();

      sent_items = 0;
      phase      = 0;
      while (sent_items < ITEM_TARGET) begin
         kind = (phase == 0) ? 3 : $urandom_range(0, 11);
         n    = (phase == 0) ? 150 : $urandom_range(8, 100);
         case (kind)
            0: begin
               rin  = $urandom_range(1, 64);
               rout = $urandom_range(0, 1) ? 0 : rin + $urandom_range(1, 5);
               n    = $urandom_range(2, 6);
            end
            1: begin
               rin  = RATE_MAX;
               rout = RATE_MAX - $urandom_range(0, 3);
            end
            2: begin
               rin  = $urandom_range(RATE_MAX / 2, RATE_MAX);
               rout = $urandom_range(1, 4);
               n    = $urandom_range(1, 6);
            end
            3: begin
               rin  = $urandom_range(1, RATE_MAX);
               rout = rin;
            end
            4: begin
               rin  = $urandom_range(0, 1) ? 48000 : 44100;
               rout = $urandom_range(rin / 8, rin);
            end
            5, 6, 7: begin
               rin  = $urandom_range(1, 12);
               rout = $urandom_range(1, rin);
            end
            default: begin
               rin  = $urandom_range(13, 5000);
               rout = $urandom_range(rin / 8 + 1, rin);
            end
         endcase

         case ($urandom_range(0, 7))
            0:       ic = COUNT_MAX;
            1:       ic = 0;
            2:       ic = n + $urandom_range(1, 5);
            3:       ic = n;
            default: ic = (n > 3) ? n - $urandom_range(0, 3) : n;
         endcase
         if (phase == 0) ic = n;

         full = (2 * ic * rout + rin) / (2 * rin);
         if (full > COUNT_MAX) full = COUNT_MAX;
         case ($urandom_range(0, 7))
            0:       oc = COUNT_MAX;
            1:       oc = $urandom_range(0, full);
            2:       oc = full + $urandom_range(1, 3);
            default: oc = full;
         endcase
         if (phase == 0) oc = full;
         if (oc > COUNT_MAX) oc = COUNT_MAX;

         configure(rin, rout, ic, oc);
         if (phase == 0) pressure_on = 1'b1;
         run_random_phase(n);
         sent_items += n;
         phase++;
      end

      if (error_count == 0)
         $display("PASS box_filter_fractional_decimator_unit");
      else
         $display("FAIL box_filter_fractional_decimator_unit");
      $finish;
   end

endmodule
